### src/mdio_management_frame_master_macros.svh
// Assertion macros for the MDIO management master checks.
`ifndef MDIO_MANAGEMENT_FRAME_MASTER_MACROS_SVH
`define MDIO_MANAGEMENT_FRAME_MASTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define MMFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdio master check failed");

// Next-cycle implication.
`define MMFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdio master check failed");

`endif

### src/mmfm_pkg.sv
package mmfm_pkg;

  localparam int PREAMBLE_BITS = 32;
  localparam int FRAME_BITS    = PREAMBLE_BITS + 32;
  localparam int PHY_W         = 5;
  localparam int REG_W         = 5;
  localparam int DATA_W        = 16;
  localparam int OP_W          = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // One frame bit as held by a cell.
  typedef struct packed {
    logic       val;      // bit to drive when not a PHY address bit
    logic       drive;    // master owns the line
    logic       last;     // final bit of the frame
    logic       sample;   // read data bit: capture mdio_in
    logic       phy;      // take the bit from the PHY address register
    logic [2:0] phy_idx;  // which PHY address bit
  } frame_cell_t;

  typedef frame_cell_t [FRAME_BITS-1:0] frame_image_t;

  typedef struct packed {
    logic load;     // load the whole chain with a new frame
    logic advance;  // one MDC period: shift toward the head
  } chain_ctrl_t;

  typedef struct packed {
    logic              mdio_out;
    logic              mdio_drive;
    logic              clock_pulse;
    logic              frame_busy;
    logic              start_rejected;
    logic              frame_done;
    logic              read_valid;
    logic [DATA_W-1:0] read_data;
  } result_t;

  // Frame image, index 0 goes out first.
  function automatic frame_image_t build_frame(input logic              is_rd,
                                               input logic [REG_W-1:0]  reg_addr,
                                               input logic [DATA_W-1:0] wdata);
    frame_image_t img;
    int           k;
    img = '0;
    for (int i = 0; i < FRAME_BITS; i++) begin
      k = i - PREAMBLE_BITS;
      img[i].drive = 1'b1;
      if (k < 0) begin
        img[i].val = 1'b1;
      end else if (k < 2) begin
        img[i].val = (k == 1);
      end else if (k < 4) begin
        img[i].val = is_rd ? (k == 2) : (k == 3);
      end else if (k < 9) begin
        img[i].phy     = 1'b1;
        img[i].phy_idx = 3'(8 - k);
      end else if (k < 14) begin
        img[i].val = reg_addr[3'(13 - k)];
      end else if (k < 16) begin
        img[i].drive = !is_rd;
        img[i].val   = !is_rd && (k == 14);
      end else begin
        img[i].drive  = !is_rd;
        img[i].sample = is_rd;
        img[i].val    = !is_rd && wdata[4'(31 - k)];
      end
      img[i].last = (k == 31);
    end
    return img;
  endfunction

endpackage

### src/mmfm_intf.sv
interface mmfm_in_if;
  import mmfm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic [REG_W-1:0]       register_address;
  logic [DATA_W-1:0]      write_data;
  logic                   mdio_in;

  modport source(output valid, operation, register_address, write_data, mdio_in,
                 input ready);
  modport sink(input valid, operation, register_address, write_data, mdio_in,
               output ready);
endinterface

interface mmfm_out_if;
  import mmfm_pkg::*;
  logic              valid;
  logic              ready;
  logic              mdio_out;
  logic              mdio_drive;
  logic              clock_pulse;
  logic              frame_busy;
  logic              start_rejected;
  logic              frame_done;
  logic              read_valid;
  logic [DATA_W-1:0] read_data;

  modport source(output valid, mdio_out, mdio_drive, clock_pulse, frame_busy,
                 start_rejected, frame_done, read_valid, read_data,
                 input ready);
  modport sink(input valid, mdio_out, mdio_drive, clock_pulse, frame_busy,
               start_rejected, frame_done, read_valid, read_data,
               output ready);
endinterface

### src/mmfm_cell.sv
module mmfm_cell
  import mmfm_pkg::*;
(
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  frame_cell_t load_bit,
  input  frame_cell_t next_bit,
  output frame_cell_t cell_q
);

  frame_cell_t cell_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cell_r <= load_bit;
    end else if (ctrl.advance) begin
      cell_r <= next_bit;
    end
  end

  assign cell_q = cell_r;

endmodule

### src/mmfm_chain.sv
module mmfm_chain
  import mmfm_pkg::*;
(
  input  logic         clk,
  input  chain_ctrl_t  ctrl,
  input  frame_image_t image,
  output frame_cell_t  head
);

  frame_image_t cells;

  for (genvar i = 0; i < FRAME_BITS; i++) begin : g_cell
    frame_cell_t nxt;
    if (i == FRAME_BITS - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cells[i+1];
    end
    mmfm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_bit (image[i]),
      .next_bit (nxt),
      .cell_q   (cells[i])
    );
  end

  assign head = cells[0];

endmodule

### src/mdio_management_frame_master.sv
// Clause-22 MDIO management master, one MDC period per tick transfer.
// A start transfer (operation 1 read, 2 write) loads the whole frame into a
// row of PREAMBLE_BITS+32 bit cells; each tick transfer (operation 0) while
// busy shifts the row by one, drives the head bit and reports one MDC pulse.
// The PHY address bits are taken live from the cfg register as they reach
// the head. On a read the turnaround and data bits release the line and
// mdio_in is shifted into read_data, MSB first; read_valid and frame_done
// mark the last bit. Starts while busy only raise start_rejected. Every input
// transfer gives exactly one result transfer. Throughput is one transfer per
// clock while the skid stage is not full: the cell row shifts one position per
// accepted tick, and a result register with a skid stage keeps in_ch.ready
// high while one result waits for out_ch.ready. Results are registered.
module mdio_management_frame_master
  import mmfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [PHY_W-1:0] cfg_wr_data,
  mmfm_in_if.sink          in_ch,
  mmfm_out_if.source       out_ch
);

  // configuration
  logic [PHY_W-1:0]  phy_r;

  // frame state
  logic              busy_r, busy_nxt;
  logic [DATA_W-1:0] rdsh_r, rdsh_nxt;

  // result register and skid stage
  logic              ov_r, sv_r;
  result_t           main_r, skid_r;

  logic              accept, out_fire;
  op_t               op;
  chain_ctrl_t       ctrl, ctrl_raw;
  frame_cell_t       head;
  frame_image_t      image;
  result_t           res;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_fire = ov_r && out_ch.ready;
  assign op       = op_t'(in_ch.operation);

  assign image = build_frame(op == OP_READ, in_ch.register_address, in_ch.write_data);

  mmfm_chain u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .image (image),
    .head  (head)
  );

  always_comb begin
    res      = '0;
    busy_nxt = busy_r;
    rdsh_nxt = rdsh_r;
    ctrl_raw = '0;
    unique case (op)
      OP_READ, OP_WRITE: begin
        if (busy_r) begin
          res.start_rejected = 1'b1;
        end else begin
          ctrl_raw.load = 1'b1;
          busy_nxt      = 1'b1;
          rdsh_nxt      = '0;
        end
      end
      OP_TICK: begin
        if (busy_r) begin
          ctrl_raw.advance = 1'b1;
          res.clock_pulse  = 1'b1;
          res.mdio_drive   = head.drive;
          res.mdio_out     = head.drive && (head.phy ? phy_r[head.phy_idx] : head.val);
          if (head.sample) begin
            rdsh_nxt = {rdsh_r[DATA_W-2:0], in_ch.mdio_in};
          end
          if (head.last) begin
            res.frame_done = 1'b1;
            res.read_valid = head.sample;
            busy_nxt       = 1'b0;
          end
        end
      end
      default: ;  // unused selector: no effect
    endcase
    res.frame_busy = busy_nxt;
    res.read_data  = rdsh_nxt;
    ctrl.load      = accept && ctrl_raw.load;
    ctrl.advance   = accept && ctrl_raw.advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phy_r  <= '0;
      busy_r <= 1'b0;
      rdsh_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        phy_r <= cfg_wr_data;
      end
      if (accept) begin
        busy_r <= busy_nxt;
        rdsh_r <= rdsh_nxt;
      end
    end
  end

  // Result register plus skid stage; input stalls only when the skid is full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (out_fire) begin
      if (sv_r) begin
        sv_r <= 1'b0;
      end else if (!accept) begin
        ov_r <= 1'b0;
      end
    end else if (accept) begin
      if (ov_r) begin
        sv_r <= 1'b1;
      end else begin
        ov_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (sv_r) begin
        main_r <= skid_r;
      end else if (accept) begin
        main_r <= res;
      end
    end else if (accept) begin
      if (ov_r) begin
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end
  end

  assign in_ch.ready           = !sv_r;
  assign out_ch.valid          = ov_r;
  assign out_ch.mdio_out       = main_r.mdio_out;
  assign out_ch.mdio_drive     = main_r.mdio_drive;
  assign out_ch.clock_pulse    = main_r.clock_pulse;
  assign out_ch.frame_busy     = main_r.frame_busy;
  assign out_ch.start_rejected = main_r.start_rejected;
  assign out_ch.frame_done     = main_r.frame_done;
  assign out_ch.read_valid     = main_r.read_valid;
  assign out_ch.read_data      = main_r.read_data;

endmodule

### src/mmfm_checker.sv
`include "mdio_management_frame_master_macros.svh"

module mmfm_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic mdio_out,
  input logic mdio_drive,
  input logic clock_pulse,
  input logic frame_busy,
  input logic frame_done,
  input logic read_valid
);

  `MMFM_ASSERT_NOW(a_drive_needs_pulse, clk, rst_n, out_valid && mdio_drive, clock_pulse)
  `MMFM_ASSERT_NOW(a_released_low, clk, rst_n, out_valid && !mdio_drive, !mdio_out)
  `MMFM_ASSERT_NOW(a_done_ends_busy, clk, rst_n, out_valid && frame_done, !frame_busy)
  `MMFM_ASSERT_NOW(a_rvalid_on_done, clk, rst_n, out_valid && read_valid, frame_done && !mdio_drive)
  `MMFM_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(frame_busy))

endmodule

bind mdio_management_frame_master mmfm_checker u_mmfm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .mdio_out       (out_ch.mdio_out),
  .mdio_drive     (out_ch.mdio_drive),
  .clock_pulse    (out_ch.clock_pulse),
  .frame_busy     (out_ch.frame_busy),
  .frame_done     (out_ch.frame_done),
  .read_valid     (out_ch.read_valid)
);

### tb/mdio_management_frame_master_tb.sv
module mdio_management_frame_master_tb;
  import mmfm_pkg::*;

  // Operation code with no meaning: the block must treat it as a no-op.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Mode of the mdio_in level fed during a frame.
  localparam int MDIN_RANDOM = 0;
  localparam int MDIN_ZEROS  = 1;
  localparam int MDIN_ONES   = 2;

  localparam int FRAME_TICKS    = PREAMBLE_BITS + 32;
  localparam int ITEMS_PER_STEP = 120;   // items per phy address setting
  localparam int HOLD_AFTER     = 400;   // results seen before the long receiver hold
  localparam int HOLD_CYCLES    = 80;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [REG_W-1:0]  regnum;
    logic [DATA_W-1:0] wdata;
    logic              mdio_in;
  } mdio_item_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [PHY_W-1:0] cfg_wr_data;

  mmfm_in_if  in_ch ();
  mmfm_out_if out_ch ();

  mdio_management_frame_master dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame predictor: a private copy of the master's state, advanced once per
  // accepted input transfer. fm_phy mirrors the cfg register.
  // ---------------------------------------------------------------------------
  logic              fm_busy;
  logic              fm_read;
  logic [6:0]        fm_pos;
  logic [REG_W-1:0]  fm_regnum;
  logic [DATA_W-1:0] fm_wdata;
  logic [DATA_W-1:0] fm_shift;
  logic [PHY_W-1:0]  fm_phy;

  function automatic result_t frame_step(input mdio_item_t it);
    result_t r;
    int      k;
    r = '0;
    if (it.op == OP_READ || it.op == OP_WRITE) begin
      if (fm_busy) begin
        r.start_rejected = 1'b1;
      end else begin
        fm_busy   = 1'b1;
        fm_read   = (it.op == OP_READ);
        fm_pos    = '0;
        fm_regnum = it.regnum;
        fm_wdata  = (it.op == OP_WRITE) ? it.wdata : '0;
        fm_shift  = '0;
      end
    end else if (it.op == OP_TICK && fm_busy) begin
      r.clock_pulse = 1'b1;
      r.mdio_drive  = 1'b1;
      if (int'(fm_pos) < PREAMBLE_BITS) begin
        r.mdio_out = 1'b1;
      end else begin
        k = int'(fm_pos) - PREAMBLE_BITS;
        if (k < 2) begin
          r.mdio_out = (k == 1);                       // start pattern 01
        end else if (k < 4) begin
          r.mdio_out = fm_read ? (k == 2) : (k == 3);  // opcode 10 / 01
        end else if (k < 9) begin
          r.mdio_out = fm_phy[8 - k];
        end else if (k < 14) begin
          r.mdio_out = fm_regnum[13 - k];
        end else if (k < 16) begin
          // turnaround: write drives 10, read lets go of the line
          if (fm_read) r.mdio_drive = 1'b0;
          else         r.mdio_out   = (k == 14);
        end else begin
          if (fm_read) begin
            r.mdio_drive = 1'b0;
            fm_shift     = {fm_shift[DATA_W-2:0], it.mdio_in};
          end else begin
            r.mdio_out = fm_wdata[31 - k];
          end
        end
        if (k >= 31) begin
          r.frame_done = 1'b1;
          r.read_valid = fm_read;
          fm_busy      = 1'b0;
        end
      end
      fm_pos = fm_busy ? fm_pos + 7'd1 : '0;
    end
    r.frame_busy = fm_busy;
    r.read_data  = fm_shift;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store, expected results and error bookkeeping.
  // ---------------------------------------------------------------------------
  mdio_item_t pending_q[$];
  result_t    expected_q[$];
  int         errors;
  int         results_seen;
  int         gap_max;

  task automatic add_item(input logic [OP_W-1:0] op, input logic [REG_W-1:0] regnum,
                          input logic [DATA_W-1:0] wdata, input logic mdio_in);
    mdio_item_t it;
    it.op      = op;
    it.regnum  = regnum;
    it.wdata   = wdata;
    it.mdio_in = mdio_in;
    pending_q.push_back(it);
  endtask

  // n tick transfers; noise_pct of the time a junk transfer (unused op or a
  // start that must bounce) is slipped in ahead of a tick.
  task automatic add_ticks(input int n, input int noise_pct, input int mdin_mode);
    logic [OP_W-1:0] nop;
    logic            lvl;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       nop = OP_UNUSED;
          1:       nop = OP_READ;
          default: nop = OP_WRITE;
        endcase
        add_item(nop, REG_W'($urandom), DATA_W'($urandom), 1'($urandom));
      end
      case (mdin_mode)
        MDIN_ZEROS: lvl = 1'b0;
        MDIN_ONES:  lvl = 1'b1;
        default:    lvl = 1'($urandom);
      endcase
      add_item(OP_TICK, REG_W'($urandom), DATA_W'($urandom), lvl);
    end
  endtask

  task automatic add_frame(input logic is_rd, input logic [REG_W-1:0] regnum,
                           input logic [DATA_W-1:0] wdata, input int noise_pct,
                           input int mdin_mode);
    add_item(is_rd ? OP_READ : OP_WRITE, regnum, wdata, 1'($urandom));
    add_ticks(FRAME_TICKS, noise_pct, mdin_mode);
  endtask

  // Block until the sender is empty and every expected result has come back.
  task automatic drain();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_ch.valid || expected_q.size() != 0);
  endtask

  task automatic set_phy(input logic [PHY_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    fm_phy = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps; gap_max = 0
  // gives a back-to-back stretch.
  // ---------------------------------------------------------------------------
  int         burst_left;
  int         gap_left;
  mdio_item_t drv_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_q.size() > 0) begin
        drv_item = pending_q.pop_front();
        in_ch.valid            <= 1'b1;
        in_ch.operation        <= drv_item.op;
        in_ch.register_address <= drv_item.regnum;
        in_ch.write_data       <= drv_item.wdata;
        in_ch.mdio_in          <= drv_item.mdio_in;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = $urandom_range(0, gap_max);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, picked anew at random, plus one long
  // hold-off so the skid stage fills and input ready drops.
  // ---------------------------------------------------------------------------
  int rx_mode;
  int rx_mode_left;
  int rx_cycle;
  int hold_left;
  bit long_hold_done;

  always @(posedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left      = HOLD_CYCLES;
      out_ch.ready  <= 1'b0;
    end else begin
      if (rx_mode_left <= 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 80);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 9) < 4);
        default: out_ch.ready <= ((rx_cycle % 4) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare a result transfer against the oldest expectation, then
  // predict for the input transfer accepted at the same edge.
  // ---------------------------------------------------------------------------
  result_t    want;
  mdio_item_t seen_item;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected", $time);
        end else begin
          want = expected_q.pop_front();
          check_field("mdio_out",       32'(want.mdio_out),       32'(out_ch.mdio_out));
          check_field("mdio_drive",     32'(want.mdio_drive),     32'(out_ch.mdio_drive));
          check_field("clock_pulse",    32'(want.clock_pulse),    32'(out_ch.clock_pulse));
          check_field("frame_busy",     32'(want.frame_busy),     32'(out_ch.frame_busy));
          check_field("start_rejected", 32'(want.start_rejected),
                      32'(out_ch.start_rejected));
          check_field("frame_done",     32'(want.frame_done),     32'(out_ch.frame_done));
          check_field("read_valid",     32'(want.read_valid),     32'(out_ch.read_valid));
          check_field("read_data",      32'(want.read_data),      32'(out_ch.read_data));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_item.op      = in_ch.operation;
        seen_item.regnum  = in_ch.register_address;
        seen_item.wdata   = in_ch.write_data;
        seen_item.mdio_in = in_ch.mdio_in;
        expected_q.push_back(frame_step(seen_item));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: reset, directed corner cases, then random frames under a series
  // of phy address settings. Config writes only happen once fully drained.
  // ---------------------------------------------------------------------------
  logic [PHY_W-1:0] phy_plan [6];
  int               step_start;

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_ch.valid            = 1'b0;
    in_ch.operation        = OP_TICK;
    in_ch.register_address = '0;
    in_ch.write_data       = '0;
    in_ch.mdio_in          = 1'b0;
    out_ch.ready = 1'b0;
    errors       = 0;
    results_seen = 0;
    gap_max      = 4;
    burst_left   = 1;
    gap_left     = 0;
    fm_busy   = 1'b0;
    fm_read   = 1'b0;
    fm_pos    = '0;
    fm_regnum = '0;
    fm_wdata  = '0;
    fm_shift  = '0;
    fm_phy    = '0;

    // first setting is the reset value, then both extremes and alternating bits
    phy_plan = '{5'd0, 5'd31, 5'd21, 5'd0, 5'd10, 5'($urandom)};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no-op code with all ones and all zeros, tick while idle.
    add_item(OP_UNUSED, '1, '1, 1'b1);
    add_item(OP_UNUSED, '0, '0, 1'b0);
    add_item(OP_TICK, '1, '1, 1'b1);
    add_item(OP_TICK, '0, '0, 1'b0);
    // Write with all-ones data; starts while busy must bounce, no-op has no effect.
    add_item(OP_WRITE, '1, 16'hFFFF, 1'b0);
    add_item(OP_READ, '0, '0, 1'b1);
    add_item(OP_WRITE, '0, 16'h0000, 1'b1);
    add_item(OP_UNUSED, '1, '1, 1'b1);
    add_ticks(FRAME_TICKS, 0, MDIN_RANDOM);
    // Tick right after the frame end: idle again.
    add_item(OP_TICK, '0, '0, 1'b1);
    add_frame(1'b1, '0, '1, 0, MDIN_ONES);
    add_frame(1'b0, '0, '0, 0, MDIN_RANDOM);
    add_frame(1'b1, '1, '0, 0, MDIN_ZEROS);
    // back-to-back read right after a write, alternating register address bits
    add_frame(1'b0, 5'h15, 16'hA5C3, 0, MDIN_RANDOM);
    add_frame(1'b1, 5'h0A, 16'h0000, 0, MDIN_RANDOM);

    for (int s = 0; s < 6; s++) begin
      if (s > 0) begin
        drain();                      // sender holds off until all results are in
        repeat (3) @(posedge clk);
        set_phy(phy_plan[s]);
      end
      gap_max    = (s == 2) ? 0 : $urandom_range(2, 8);
      step_start = pending_q.size();
      if (s > 0) begin
        // extremes once more under the new address
        add_frame(1'b0, '1, '1, 0, MDIN_RANDOM);
        add_frame(1'b1, '0, '0, 0, MDIN_ONES);
      end
      while (pending_q.size() - step_start < ITEMS_PER_STEP) begin
        if ($urandom_range(0, 99) < 85) begin
          add_frame(1'($urandom), REG_W'($urandom), DATA_W'($urandom),
                    $urandom_range(0, 8),
                    ($urandom_range(0, 9) < 8) ? MDIN_RANDOM : $urandom_range(1, 2));
        end else begin
          // idle noise between frames
          repeat ($urandom_range(1, 4))
            add_item($urandom_range(0, 1) ? OP_UNUSED : OP_TICK,
                     REG_W'($urandom), DATA_W'($urandom), 1'($urandom));
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
